// ===== design/set_assoc_cache_tag_array_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_CACHE_TAG_ARRAY_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_ARRAY_CORE_DEFINES_SVH

// Plain property, sampled on clk_i, off during reset.
`define SACT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sact_pkg.sv =====
`default_nettype none
package sact_pkg;

  localparam int unsigned WAYS_DEF   = 4;
  localparam int unsigned SETS_DEF   = 256;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned INSTR_W    = 16;
  localparam int unsigned LAT_W      = 11;
  localparam int unsigned CNT_W      = 40;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned AGE_W      = 32;
  localparam int unsigned WAY_OUT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned RAW_SET_W  = 15;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned NUM_CNT    = 8;

  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_SHIFT     = 3'd0,
    REG_INDEX_WIDTH    = 3'd1,
    REG_REPLACE_FIFO   = 3'd2,
    REG_FILL_PENALTY   = 3'd3,
    REG_ALLOC_ON_STORE = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    C_ACC = 3'd0, C_HIT = 3'd1, C_LD = 3'd2, C_LDH = 3'd3,
    C_ST  = 3'd4, C_STH = 3'd5, C_CYC = 3'd6, C_MEM = 3'd7
  } cnt_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_e;

  typedef struct packed {
    logic [3:0] line_shift;
    logic [3:0] index_width;
    logic       replace_fifo;
    logic [9:0] fill_penalty;
    logic       alloc_on_store;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [CNT_W-1:0] v);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {1'b0, v};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // Remainder by a constant divisor (up to 4096): reciprocal multiply with a
  // 29-bit scale is exact for any 16-bit value, then one multiply-subtract.
  function automatic logic [15:0] reduce_mod(input logic [15:0] value,
                                              input int unsigned divisor);
    logic [63:0] recip;
    logic [63:0] prod;
    logic [15:0] quo;
    logic [31:0] back_prod;
    recip     = ((64'd1 << 29) + 64'(divisor) - 64'd1) / 64'(divisor);
    prod      = 64'(value) * recip;
    quo       = prod[44:29];
    back_prod = 32'(quo) * 32'(divisor);
    return value - back_prod[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/sact_if.sv =====
`default_nettype none
interface sact_in_if;
  import sact_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [ADDR_W-1:0]  address;
  logic [INSTR_W-1:0] instructions;
  modport source (output valid, func, address, instructions, input ready);
  modport sink   (input valid, func, address, instructions, output ready);
endinterface

interface sact_out_if;
  import sact_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [LAT_W-1:0]     latency;
  logic [WAY_OUT_W-1:0] way;
  logic [CNT_W-1:0]     access_count;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     load_count;
  logic [CNT_W-1:0]     load_hit_count;
  logic [CNT_W-1:0]     store_count;
  logic [CNT_W-1:0]     store_hit_count;
  logic [CNT_W-1:0]     cycle_total;
  logic [CNT_W-1:0]     memory_cycle_total;
  modport source (output valid, hit, latency, way, access_count, hit_count, load_count,
                  load_hit_count, store_count, store_hit_count, cycle_total,
                  memory_cycle_total, input ready);
  modport sink   (input valid, hit, latency, way, access_count, hit_count, load_count,
                  load_hit_count, store_count, store_hit_count, cycle_total,
                  memory_cycle_total, output ready);
endinterface

interface sact_cfg_if;
  import sact_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/sact_front.sv =====
`default_nettype none
module sact_front import sact_pkg::*; #(
  parameter int unsigned SETS = SETS_DEF,
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  sact_in_if.sink          in_i,
  input  cfg_t             cfg_i,
  output logic             item_valid_o,
  input  wire              item_ready_i,
  output logic             item_func_o,
  output logic [SET_W-1:0] item_set_o,
  output logic [TAG_W-1:0] item_tag_o,
  output logic [INSTR_W-1:0] item_instr_o
);

  // decode
  logic [ADDR_W-1:0]    shifted;
  logic [RAW_SET_W-1:0] set_mask;
  logic [RAW_SET_W-1:0] raw_set;
  logic [15:0]          red_set;
  logic [4:0]           tag_shift;
  logic [SET_W-1:0]     dec_set;
  logic [TAG_W-1:0]     dec_tag;

  always_comb begin
    shifted   = in_i.address >> cfg_i.line_shift;
    set_mask  = RAW_SET_W'((16'd1 << cfg_i.index_width) - 16'd1);
    raw_set   = shifted[RAW_SET_W-1:0] & set_mask;
    red_set   = reduce_mod({1'b0, raw_set}, SETS);
    dec_set   = SET_W'(red_set);
    tag_shift = {1'b0, cfg_i.line_shift} + {1'b0, cfg_i.index_width};
    dec_tag   = in_i.address >> tag_shift;
  end

  // two-entry queue to the back end
  logic             func_q  [2];
  logic [SET_W-1:0] set_q   [2];
  logic [TAG_W-1:0] tag_q   [2];
  logic [INSTR_W-1:0] instr_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;

  assign item_func_o  = func_q[rd_ptr_q];
  assign item_set_o   = set_q[rd_ptr_q];
  assign item_tag_o   = tag_q[rd_ptr_q];
  assign item_instr_o = instr_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      func_q[wr_ptr_q]  <= in_i.func;
      set_q[wr_ptr_q]   <= dec_set;
      tag_q[wr_ptr_q]   <= dec_tag;
      instr_q[wr_ptr_q] <= in_i.instructions;
    end
  end

endmodule
`default_nettype wire

// ===== design/sact_back.sv =====
`default_nettype none
module sact_back import sact_pkg::*; #(
  parameter int unsigned WAYS = WAYS_DEF,
  parameter int unsigned SETS = SETS_DEF,
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cfg_t               cfg_i,
  input  wire                item_valid_i,
  output logic               item_ready_o,
  input  wire                item_func_i,
  input  wire [SET_W-1:0]    item_set_i,
  input  wire [TAG_W-1:0]    item_tag_i,
  input  wire [INSTR_W-1:0]  item_instr_i,
  sact_out_if.source         out_o
);

  // set-indexed stores, one row per set
  logic [WAYS-1:0]  valid_mem [SETS];
  logic [TAG_W-1:0] tag_mem   [SETS][WAYS];
  logic [AGE_W-1:0] age_mem   [SETS][WAYS];
  logic [AGE_W-1:0] fill_mem  [SETS];

  logic [WAYS-1:0]  valid_rd_q;
  logic [TAG_W-1:0] tag_rd_q [WAYS];
  logic [AGE_W-1:0] age_rd_q [WAYS];
  logic [AGE_W-1:0] fill_rd_q;

  back_state_e state_q, state_d;
  logic [SET_W-1:0] clr_q, clr_d;
  logic             clr_last;

  logic             func_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [INSTR_W-1:0] instr_q;

  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [CNT_W-1:0]  cnt_q [NUM_CNT];
  logic [CNT_W-1:0]  cnt_d [NUM_CNT];

  logic out_free, pop, look;

  // lookup and victim choice
  logic             hit, any_inv, need_fill, use_rand, is_store;
  logic [WAY_W-1:0] hit_way, inv_way, old_way, rand_way, victim;
  logic [AGE_W-1:0] oldest;
  logic [LFSR_W-1:0] lfsr_nx;
  logic [15:0]      rand_red;
  logic [LAT_W-1:0] latency;
  logic [WAY_W-1:0] way_res;

  assign clr_last = (clr_q == SET_W'(SETS - 1));
  assign out_free = !out_o.valid || out_o.ready;
  assign item_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop  = item_valid_i && item_ready_o;
  assign look = (state_q == ST_LOOK);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) state_d = ST_LOOK;
      end
      ST_LOOK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    is_store = (func_e'(func_q) == FUNC_STORE);
    hit = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && valid_rd_q[i] && tag_rd_q[i] == tag_q) begin
        hit = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!any_inv && !valid_rd_q[i]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(i);
      end
    end
    oldest  = age_rd_q[0];
    old_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (age_rd_q[i] < oldest) begin
        oldest  = age_rd_q[i];
        old_way = WAY_W'(i);
      end
    end
    lfsr_nx   = lfsr_next(lfsr_q);
    rand_red  = reduce_mod(lfsr_nx, WAYS);
    rand_way  = WAY_W'(rand_red);
    need_fill = !hit && !(is_store && !cfg_i.alloc_on_store);
    use_rand  = need_fill && !any_inv && !cfg_i.replace_fifo;
    victim    = any_inv ? inv_way : (cfg_i.replace_fifo ? old_way : rand_way);
    latency   = hit ? LAT_W'(1) : LAT_W'(1) + LAT_W'(cfg_i.fill_penalty);
    way_res   = hit ? hit_way : (need_fill ? victim : '0);
    lfsr_d    = (look && use_rand) ? lfsr_nx : lfsr_q;
  end

  // running counters
  always_comb begin
    for (int c = 0; c < NUM_CNT; c++) cnt_d[c] = cnt_q[c];
    cnt_d[C_ACC] = sat_add(cnt_q[C_ACC], CNT_W'(1));
    if (is_store) cnt_d[C_ST] = sat_add(cnt_q[C_ST], CNT_W'(1));
    else          cnt_d[C_LD] = sat_add(cnt_q[C_LD], CNT_W'(1));
    if (hit) begin
      cnt_d[C_HIT] = sat_add(cnt_q[C_HIT], CNT_W'(1));
      if (is_store) cnt_d[C_STH] = sat_add(cnt_q[C_STH], CNT_W'(1));
      else          cnt_d[C_LDH] = sat_add(cnt_q[C_LDH], CNT_W'(1));
    end
    cnt_d[C_MEM] = sat_add(cnt_q[C_MEM], CNT_W'(latency));
    cnt_d[C_CYC] = sat_add(cnt_q[C_CYC], CNT_W'(instr_q) + CNT_W'(latency));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      lfsr_q  <= LFSR_SEED;
      out_o.valid <= 1'b0;
      for (int c = 0; c < NUM_CNT; c++) cnt_q[c] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lfsr_q  <= lfsr_d;
      if (look) begin
        out_o.valid <= 1'b1;
        for (int c = 0; c < NUM_CNT; c++) cnt_q[c] <= cnt_d[c];
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      func_q  <= item_func_i;
      set_q   <= item_set_i;
      tag_q   <= item_tag_i;
      instr_q <= item_instr_i;
    end
    if (look) begin
      out_o.hit                <= hit;
      out_o.latency            <= latency;
      out_o.way                <= WAY_OUT_W'(way_res);
      out_o.access_count       <= cnt_d[C_ACC];
      out_o.hit_count          <= cnt_d[C_HIT];
      out_o.load_count         <= cnt_d[C_LD];
      out_o.load_hit_count     <= cnt_d[C_LDH];
      out_o.store_count        <= cnt_d[C_ST];
      out_o.store_hit_count    <= cnt_d[C_STH];
      out_o.cycle_total        <= cnt_d[C_CYC];
      out_o.memory_cycle_total <= cnt_d[C_MEM];
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      valid_mem[clr_q] <= '0;
      fill_mem[clr_q]  <= '0;
    end else if (look && need_fill) begin
      valid_mem[set_q][victim] <= 1'b1;
      tag_mem[set_q][victim]   <= tag_q;
      age_mem[set_q][victim]   <= fill_rd_q;
      fill_mem[set_q]          <= fill_rd_q + AGE_W'(1);
    end
    if (pop) begin
      valid_rd_q <= valid_mem[item_set_i];
      fill_rd_q  <= fill_mem[item_set_i];
      for (int i = 0; i < WAYS; i++) begin
        tag_rd_q[i] <= tag_mem[item_set_i][i];
        age_rd_q[i] <= age_mem[item_set_i][i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/set_assoc_cache_tag_array_core.sv =====
// Tag/valid store of a set-associative cache with saturating statistics.
// Each access (load/store, byte address, instruction count) yields one result
// with hit flag, charged latency, way hit or filled (else zero), and all
// eight counters as they stand after that access. The front end decodes set
// and tag from the configured offset and set bit counts and queues up to two
// accesses; the back end reads the set row from the tag memory as it takes
// an access, then in its look state decides, writes the filled line and
// loads the result register, and takes no new access until that is done and
// the result register is free. After reset a clearing pass over all SETS
// rows zeroes valid bits and fill counters; accesses queue but are not
// processed until it ends. Configuration writes are always taken (ready tied
// high) and must only be issued while the block is idle.
`default_nettype none
module set_assoc_cache_tag_array_core import sact_pkg::*; #(
  parameter int unsigned WAYS = WAYS_DEF,
  parameter int unsigned SETS = SETS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  sact_in_if.sink   in_i,
  sact_out_if.source out_o,
  sact_cfg_if.sink  cfg_i
);

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  cfg_t cfg_q;

  // config registers; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_shift     <= 4'd5;
      cfg_q.index_width    <= 4'd8;
      cfg_q.replace_fifo   <= 1'b1;
      cfg_q.fill_penalty   <= 10'd100;
      cfg_q.alloc_on_store <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LINE_SHIFT:     cfg_q.line_shift     <= cfg_i.data[3:0];
        REG_INDEX_WIDTH:    cfg_q.index_width    <= cfg_i.data[3:0];
        REG_REPLACE_FIFO:   cfg_q.replace_fifo   <= cfg_i.data[0];
        REG_FILL_PENALTY:   cfg_q.fill_penalty   <= cfg_i.data[9:0];
        REG_ALLOC_ON_STORE: cfg_q.alloc_on_store <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // front -> back queue head
  logic             item_valid, item_ready, item_func;
  logic [SET_W-1:0] item_set;
  logic [TAG_W-1:0] item_tag;
  logic [INSTR_W-1:0] item_instr;

  sact_front #(.SETS(SETS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_func_o  (item_func),
    .item_set_o   (item_set),
    .item_tag_o   (item_tag),
    .item_instr_o (item_instr)
  );

  sact_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_func_i  (item_func),
    .item_set_i   (item_set),
    .item_tag_i   (item_tag),
    .item_instr_i (item_instr),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

// ===== design/sact_checker.sv =====
`default_nettype none
`include "set_assoc_cache_tag_array_core_defines.svh"
module sact_checker import sact_pkg::*; (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             out_valid,
  input wire             out_ready,
  input wire             out_hit,
  input wire [LAT_W-1:0] out_latency,
  input wire [CNT_W-1:0] out_access_count,
  input wire [CNT_W-1:0] out_hit_count
);

  `SACT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SACT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_access_count), "stalled result changed")
  `SACT_ASSERT_IMP(a_hit_lat, out_valid && out_hit, out_latency == LAT_W'(1), "hit latency not one")
  `SACT_ASSERT(a_hit_le_acc, !out_valid || out_hit_count <= out_access_count, "hits exceed accesses")

endmodule

bind set_assoc_cache_tag_array_core sact_checker u_sact_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .out_hit          (out_o.hit),
  .out_latency      (out_o.latency),
  .out_access_count (out_o.access_count),
  .out_hit_count    (out_o.hit_count)
);
`default_nettype wire
